// ----- sv/hcs_pkg.sv -----
package hcs_pkg;

    localparam int unsigned CHANNEL_BITS_DEF = 16;
    localparam int unsigned FRAC_BITS        = 24;
    localparam int unsigned FACTOR_FRAC      = 14;
    localparam int unsigned DIV_STEPS        = 26;
    localparam int unsigned HUE_W            = 29;
    localparam int unsigned LVL_W            = 25;

    localparam logic [15:0] FACTOR_RESET = 16'd16384;

    // Hue in degrees, 20 fraction bits
    localparam logic [HUE_W-1:0] DEG60  = 29'd62914560;
    localparam logic [HUE_W-1:0] DEG120 = 29'd125829120;
    localparam logic [HUE_W-1:0] DEG180 = 29'd188743680;
    localparam logic [HUE_W-1:0] DEG240 = 29'd251658240;
    localparam logic [HUE_W-1:0] DEG360 = 29'd377487360;

    localparam logic [LVL_W-1:0] ONE_FX  = 25'h1000000;
    localparam logic [LVL_W-1:0] HALF_FX = 25'h0800000;

    // floor(2^32 / 15)
    localparam logic [28:0] RECIP15 = 29'd286331153;

    typedef struct packed {
        logic [15:0] in_red;
        logic [15:0] in_green;
        logic [15:0] in_blue;
    } t_in_pix;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
    } t_out_pix;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        t_sector sector;
        logic    neg;
        logic    gray;
    } t_hue_ctl;

endpackage

// ----- sv/hls_color_shade.sv -----
// Channel     Direction  Handshake          Payload
// in          input      i_in_valid/o_in_stall    i_in_data  (t_in_pix)
// out         output     o_out_valid/i_out_stall  o_out_data (t_out_pix)
// cfg         input      i_cfg_valid/o_cfg_ready  i_cfg_data (shade factor, Q2.14)
//
// One color enters per cycle while o_in_stall is low; each result passes through
// the 26-stage bit-per-stage divider (saturation and hue lanes, with the
// lightness reciprocal multiply running alongside) plus front, shade and
// per-channel output stages.
// Reset is synchronous, active low; it empties the pipeline and sets the factor to 1.0.
// A held result parks in a skid register; the input stalls while that register is full,
// freezing every stage as a whole.
module hls_color_shade #(
    parameter int unsigned CHANNEL_BITS = hcs_pkg::CHANNEL_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  hcs_pkg::t_in_pix  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output hcs_pkg::t_out_pix o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [15:0]       i_cfg_data
);
    import hcs_pkg::*;

    logic [15:0] r_factor;
    logic        r_skid_valid;
    t_out_pix    r_skid;

    logic                   w_en;
    logic                   w_fr_v, w_dv_v, w_sh_v, w_cr_v, w_cg_v, w_cb_v, w_pipe_v;
    logic [CHANNEL_BITS+1:0] w_sat_rem, w_lig_rem;
    logic [CHANNEL_BITS:0]   w_sat_div;
    logic [CHANNEL_BITS+5:0] w_hue_rem;
    logic [CHANNEL_BITS-1:0] w_hue_div;
    t_hue_ctl               w_fr_ctl, w_dv_ctl;
    logic [DIV_STEPS-1:0]   w_sat_q, w_hue_q;
    logic [LVL_W-1:0]       w_lig;
    logic [LVL_W-1:0]       w_m1, w_span;
    logic [HUE_W-1:0]       w_hr, w_hg, w_hb;
    t_out_pix               w_pix;
    logic                   w_push, w_take;

    // The whole pipeline advances while the skid register is empty
    assign w_en       = !r_skid_valid;
    assign o_in_stall = r_skid_valid;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= FACTOR_RESET;
        end else if (i_cfg_valid) begin
            r_factor <= i_cfg_data;
        end
    end

    hcs_front #(.CHANNEL_BITS(CHANNEL_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_in_valid),
        .i_pix     (i_in_data),
        .o_valid   (w_fr_v),
        .o_sat_rem (w_sat_rem),
        .o_sat_div (w_sat_div),
        .o_hue_rem (w_hue_rem),
        .o_hue_div (w_hue_div),
        .o_lig_rem (w_lig_rem),
        .o_ctl     (w_fr_ctl)
    );

    hcs_divider #(.CHANNEL_BITS(CHANNEL_BITS)) u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (w_fr_v),
        .i_sat_rem     (w_sat_rem),
        .i_sat_div     (w_sat_div),
        .i_hue_rem     (w_hue_rem),
        .i_hue_div     (w_hue_div),
        .i_lig_rem     (w_lig_rem),
        .i_ctl         (w_fr_ctl),
        .o_valid       (w_dv_v),
        .o_sat_q       (w_sat_q),
        .o_hue_q       (w_hue_q),
        .o_lig         (w_lig),
        .o_ctl         (w_dv_ctl)
    );

    hcs_shade u_shade (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (w_dv_v),
        .i_factor      (r_factor),
        .i_sat_q       (w_sat_q),
        .i_hue_q       (w_hue_q),
        .i_lig         (w_lig),
        .i_ctl         (w_dv_ctl),
        .o_valid       (w_sh_v),
        .o_m1          (w_m1),
        .o_span        (w_span),
        .o_hue_r       (w_hr),
        .o_hue_g       (w_hg),
        .o_hue_b       (w_hb)
    );

    hcs_chan #(.CHANNEL_BITS(CHANNEL_BITS)) u_chan_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sh_v),
        .i_m1    (w_m1),
        .i_span  (w_span),
        .i_hue   (w_hr),
        .o_valid (w_cr_v),
        .o_chan  (w_pix.out_red)
    );

    hcs_chan #(.CHANNEL_BITS(CHANNEL_BITS)) u_chan_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sh_v),
        .i_m1    (w_m1),
        .i_span  (w_span),
        .i_hue   (w_hg),
        .o_valid (w_cg_v),
        .o_chan  (w_pix.out_green)
    );

    hcs_chan #(.CHANNEL_BITS(CHANNEL_BITS)) u_chan_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sh_v),
        .i_m1    (w_m1),
        .i_span  (w_span),
        .i_hue   (w_hb),
        .o_valid (w_cb_v),
        .o_chan  (w_pix.out_blue)
    );

    assign w_pipe_v = w_cr_v & w_cg_v & w_cb_v;
    assign w_push   = w_pipe_v && w_en;
    assign w_take   = o_out_valid && !i_out_stall;

    // Output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                o_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (!o_out_valid || w_take) begin
                o_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) o_out_data <= r_skid;
        end else if (w_push) begin
            if (!o_out_valid || w_take) o_out_data <= w_pix;
            else                        r_skid     <= w_pix;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> o_out_valid)
        else $error("skid entry held without a result in the output register");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(o_out_valid && i_out_stall && w_pipe_v))
        else $error("skid filled without a stalled output and a finished result");

    a_frozen_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !w_take) |=> ($stable(w_pipe_v) && r_skid_valid))
        else $error("pipeline moved while frozen");

    a_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cr_v == w_cg_v) && (w_cg_v == w_cb_v))
        else $error("channel lanes out of step");

endmodule

// ----- sv/hcs_front.sv -----
module hcs_front #(
    parameter int unsigned CHANNEL_BITS = hcs_pkg::CHANNEL_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  hcs_pkg::t_in_pix         i_pix,
    output logic                     o_valid,
    output logic [CHANNEL_BITS+1:0]  o_sat_rem,
    output logic [CHANNEL_BITS:0]    o_sat_div,
    output logic [CHANNEL_BITS+5:0]  o_hue_rem,
    output logic [CHANNEL_BITS-1:0]  o_hue_div,
    output logic [CHANNEL_BITS+1:0]  o_lig_rem,
    output hcs_pkg::t_hue_ctl        o_ctl
);
    import hcs_pkg::*;

    localparam int unsigned CW     = CHANNEL_BITS;
    localparam int unsigned CH_INT = (1 << CHANNEL_BITS) - 1;
    localparam logic [15:0]   CH16  = CH_INT[15:0];
    localparam logic [CW-1:0] CH    = CH_INT[CW-1:0];

    logic          r_v0;
    logic [CW-1:0] r_r, r_g, r_b;

    logic [CW-1:0] w_mx, w_mn, w_d, w_hi, w_lo, w_diff;
    logic [CW:0]   w_sum, w_den;
    logic [CW+1:0] w_den_hi;
    logic [CW+5:0] w_a;
    t_hue_ctl      w_ctl;

    // Saturate channels above the channel maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r <= (i_pix.in_red   > CH16) ? CH : i_pix.in_red[CW-1:0];
            r_g <= (i_pix.in_green > CH16) ? CH : i_pix.in_green[CW-1:0];
            r_b <= (i_pix.in_blue  > CH16) ? CH : i_pix.in_blue[CW-1:0];
        end
    end

    always_comb begin
        w_mx = r_r;
        w_mn = r_r;
        if (r_g > w_mx) w_mx = r_g;
        if (r_b > w_mx) w_mx = r_b;
        if (r_g < w_mn) w_mn = r_g;
        if (r_b < w_mn) w_mn = r_b;
        w_sum    = {1'b0, w_mx} + {1'b0, w_mn};
        w_d      = w_mx - w_mn;
        w_den_hi = {1'b0, CH, 1'b0} - {1'b0, w_sum};
        w_den    = (w_sum <= {1'b0, CH}) ? w_sum : w_den_hi[CW:0];

        w_ctl.gray = (w_mx == w_mn);
        if (r_r == w_mx) begin
            w_ctl.sector = SEC_RED;
            w_hi = r_g;
            w_lo = r_b;
        end else if (r_g == w_mx) begin
            w_ctl.sector = SEC_GREEN;
            w_hi = r_b;
            w_lo = r_r;
        end else begin
            w_ctl.sector = SEC_BLUE;
            w_hi = r_r;
            w_lo = r_g;
        end
        w_ctl.neg = (w_hi < w_lo);
        w_diff    = w_ctl.neg ? (w_lo - w_hi) : (w_hi - w_lo);
        // diff * 60
        w_a = {w_diff, 6'b0} - {4'b0, w_diff, 2'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sat_rem <= {2'b0, w_d};
            o_sat_div <= w_den;
            o_hue_rem <= w_a;
            o_hue_div <= w_d;
            o_lig_rem <= {1'b0, w_sum};
            o_ctl     <= w_ctl;
        end
    end

endmodule

// ----- sv/hcs_divider.sv -----
module hcs_divider #(
    parameter int unsigned CHANNEL_BITS = hcs_pkg::CHANNEL_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [CHANNEL_BITS+1:0]        i_sat_rem,
    input  logic [CHANNEL_BITS:0]          i_sat_div,
    input  logic [CHANNEL_BITS+5:0]        i_hue_rem,
    input  logic [CHANNEL_BITS-1:0]        i_hue_div,
    input  logic [CHANNEL_BITS+1:0]        i_lig_rem,
    input  hcs_pkg::t_hue_ctl              i_ctl,
    output logic                           o_valid,
    output logic [hcs_pkg::DIV_STEPS-1:0]  o_sat_q,
    output logic [hcs_pkg::DIV_STEPS-1:0]  o_hue_q,
    output logic [hcs_pkg::LVL_W-1:0]      o_lig,
    output hcs_pkg::t_hue_ctl              o_ctl
);
    import hcs_pkg::*;

    localparam int unsigned CW       = CHANNEL_BITS;
    localparam int unsigned SW       = CW + 2;
    localparam int unsigned HW       = CW + 6;
    localparam int unsigned N        = DIV_STEPS;
    localparam int unsigned PW       = SW + LVL_W - 1;
    localparam int unsigned RW       = CW + FRAC_BITS + 1;
    localparam longint unsigned CH_L   = (64'd1 << CHANNEL_BITS) - 64'd1;
    localparam longint unsigned LRCP_L = (64'd1 << (CHANNEL_BITS + FRAC_BITS)) / CH_L;
    localparam logic [CW-1:0]    CH      = CH_L[CW-1:0];
    localparam logic [LVL_W-1:0] LIG_RCP = LRCP_L[LVL_W-1:0];

    logic                r_v   [1:N];
    logic [SW-1:0]       r_sr  [1:N];
    logic [CW:0]         r_sd  [1:N];
    logic [HW-1:0]       r_hr  [1:N];
    logic [CW-1:0]       r_hd  [1:N];
    logic [N-1:0]        r_qs  [1:N];
    logic [N-1:0]        r_qh  [1:N];
    t_hue_ctl            r_ctl [1:N];

    logic [LVL_W-1:0]    r_lq0;
    logic [SW-1:0]       r_lsum;
    logic [LVL_W-1:0]    r_lig [2:N];

    logic [PW-1:0]       w_lprod;
    logic [RW-1:0]       w_lnum, w_lqc, w_lrem;
    logic [LVL_W-1:0]    w_lig;

    // One quotient bit per lane per stage
    for (genvar k = 0; k < N; k++) begin : g_step
        logic          c_v;
        logic [SW-1:0] c_sr, n_sr, w_sdv;
        logic [CW:0]   c_sd;
        logic [HW-1:0] c_hr, n_hr, w_hdv;
        logic [CW-1:0] c_hd;
        logic [N-1:0]  c_qs, c_qh;
        t_hue_ctl      c_ctl;
        logic          w_ges, w_geh;

        if (k == 0) begin : g_first
            assign c_v   = i_valid;
            assign c_sr  = i_sat_rem;
            assign c_sd  = i_sat_div;
            assign c_hr  = i_hue_rem;
            assign c_hd  = i_hue_div;
            assign c_qs  = '0;
            assign c_qh  = '0;
            assign c_ctl = i_ctl;
        end else begin : g_mid
            assign c_v   = r_v[k];
            assign c_sr  = r_sr[k];
            assign c_sd  = r_sd[k];
            assign c_hr  = r_hr[k];
            assign c_hd  = r_hd[k];
            assign c_qs  = r_qs[k];
            assign c_qh  = r_qh[k];
            assign c_ctl = r_ctl[k];
        end

        always_comb begin
            w_sdv = {1'b0, c_sd};
            w_hdv = {1'b0, c_hd, 5'b0};
            w_ges = (c_sr >= w_sdv);
            w_geh = (c_hr >= w_hdv);
            n_sr  = w_ges ? (c_sr - w_sdv) : c_sr;
            n_hr  = w_geh ? (c_hr - w_hdv) : c_hr;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= c_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sr[k+1]  <= {n_sr[SW-2:0], 1'b0};
                r_hr[k+1]  <= {n_hr[HW-2:0], 1'b0};
                r_sd[k+1]  <= c_sd;
                r_hd[k+1]  <= c_hd;
                r_qs[k+1]  <= {c_qs[N-2:0], w_ges};
                r_qh[k+1]  <= {c_qh[N-2:0], w_geh};
                r_ctl[k+1] <= c_ctl;
            end
        end
    end

    // Lightness: reciprocal estimate that is low by at most one, then fix up and round up
    assign w_lprod = {{(LVL_W-1){1'b0}}, i_lig_rem} * {{(SW-1){1'b0}}, LIG_RCP};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lq0  <= w_lprod[CW+LVL_W:CW+1];
            r_lsum <= i_lig_rem;
        end
    end

    always_comb begin
        w_lnum = {r_lsum, {(FRAC_BITS-1){1'b0}}};
        w_lqc  = {r_lq0, {CW{1'b0}}} - {{CW{1'b0}}, r_lq0};
        w_lrem = w_lnum - w_lqc;
        w_lig  = r_lq0 + LVL_W'(w_lrem[CW:0] != '0)
                       + LVL_W'(w_lrem[CW:0] > {1'b0, CH});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lig[2] <= w_lig;
        end
    end

    for (genvar j = 2; j < N; j++) begin : g_lig_dly
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lig[j+1] <= r_lig[j];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_sat_q = r_qs[N];
    assign o_hue_q = r_qh[N];
    assign o_lig   = r_lig[N];
    assign o_ctl   = r_ctl[N];

endmodule

// ----- sv/hcs_shade.sv -----
module hcs_shade (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [15:0]                   i_factor,
    input  logic [hcs_pkg::DIV_STEPS-1:0] i_sat_q,
    input  logic [hcs_pkg::DIV_STEPS-1:0] i_hue_q,
    input  logic [hcs_pkg::LVL_W-1:0]     i_lig,
    input  hcs_pkg::t_hue_ctl             i_ctl,
    output logic                          o_valid,
    output logic [hcs_pkg::LVL_W-1:0]     o_m1,
    output logic [hcs_pkg::LVL_W-1:0]     o_span,
    output logic [hcs_pkg::HUE_W-1:0]     o_hue_r,
    output logic [hcs_pkg::HUE_W-1:0]     o_hue_g,
    output logic [hcs_pkg::HUE_W-1:0]     o_hue_b
);
    import hcs_pkg::*;

    function automatic logic [HUE_W-1:0] hue_add(input logic [HUE_W-1:0] h,
                                                 input logic [HUE_W-1:0] d);
        logic [HUE_W:0] s;
        s = {1'b0, h} + {1'b0, d};
        if (s >= {1'b0, DEG360}) s = s - {1'b0, DEG360};
        return s[HUE_W-1:0];
    endfunction

    logic [3:0]       r_v;
    logic [LVL_W-1:0] r_lig, r_sat;
    logic [HUE_W-1:0] r_hue;
    logic [40:0]      r_lk, r_sk;
    logic [HUE_W-1:0] r_h1r, r_h1g, r_h1b, r_h2r, r_h2g, r_h2b;
    logic [LVL_W-1:0] r_ls, r_ss, r_prod;

    logic [HUE_W:0]   w_base, w_hsum, w_hwrap;
    logic [LVL_W-1:0] w_ls, w_ss, w_m2, w_m1;
    logic [49:0]      w_pp;
    logic [LVL_W:0]   w_m2a, w_m1a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // Finish saturation and hue
    always_comb begin
        unique case (i_ctl.sector)
            SEC_GREEN: w_base = {1'b0, DEG120};
            SEC_BLUE:  w_base = {1'b0, DEG240};
            default:   w_base = '0;
        endcase
        if (i_ctl.neg) w_hsum = w_base + {1'b0, DEG360} - {4'b0, i_hue_q};
        else           w_hsum = w_base + {4'b0, i_hue_q};
        w_hwrap = (w_hsum >= {1'b0, DEG360}) ? (w_hsum - {1'b0, DEG360}) : w_hsum;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lig <= i_lig;
            r_sat <= i_ctl.gray ? '0 : i_sat_q[DIV_STEPS-1:1];
            r_hue <= w_hwrap[HUE_W-1:0];
        end
    end

    // Apply the factor, spread the three channel hues
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lk  <= r_lig * i_factor;
            r_sk  <= r_sat * i_factor;
            r_h1r <= hue_add(r_hue, DEG120);
            r_h1g <= r_hue;
            r_h1b <= hue_add(r_hue, DEG240);
        end
    end

    // Clamp to 1.0, then L*S
    always_comb begin
        w_ls = (r_lk[40:FACTOR_FRAC] > 27'(ONE_FX)) ? ONE_FX : r_lk[38:FACTOR_FRAC];
        w_ss = (r_sk[40:FACTOR_FRAC] > 27'(ONE_FX)) ? ONE_FX : r_sk[38:FACTOR_FRAC];
        w_pp = w_ls * w_ss;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ls   <= w_ls;
            r_ss   <= w_ss;
            r_prod <= w_pp[48:FRAC_BITS];
            r_h2r  <= r_h1r;
            r_h2g  <= r_h1g;
            r_h2b  <= r_h1b;
        end
    end

    always_comb begin
        if (r_ls <= HALF_FX) w_m2a = {1'b0, r_ls} + {1'b0, r_prod};
        else                 w_m2a = {1'b0, r_ls} + {1'b0, r_ss} - {1'b0, r_prod};
        if (w_m2a > {1'b0, ONE_FX})    w_m2 = ONE_FX;
        else if (w_m2a < {1'b0, r_ls}) w_m2 = r_ls;
        else                           w_m2 = w_m2a[LVL_W-1:0];
        w_m1a = {r_ls, 1'b0} - {1'b0, w_m2};
        w_m1  = w_m1a[LVL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_m1    <= w_m1;
            o_span  <= w_m2 - w_m1;
            o_hue_r <= r_h2r;
            o_hue_g <= r_h2g;
            o_hue_b <= r_h2b;
        end
    end

    assign o_valid = r_v[3];

endmodule

// ----- sv/hcs_chan.sv -----
module hcs_chan #(
    parameter int unsigned CHANNEL_BITS = hcs_pkg::CHANNEL_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [hcs_pkg::LVL_W-1:0] i_m1,
    input  logic [hcs_pkg::LVL_W-1:0] i_span,
    input  logic [hcs_pkg::HUE_W-1:0] i_hue,
    output logic                      o_valid,
    output logic [15:0]               o_chan
);
    import hcs_pkg::*;

    typedef enum logic [1:0] {
        SEL_RAMP = 2'd0,
        SEL_HIGH = 2'd1,
        SEL_LOW  = 2'd2
    } t_lvl_sel;

    localparam int unsigned CW     = CHANNEL_BITS;
    localparam int unsigned CH_INT = (1 << CHANNEL_BITS) - 1;
    localparam logic [CW-1:0] CH   = CH_INT[CW-1:0];
    localparam int unsigned TW     = LVL_W + CW;

    logic [3:0]       r_v;
    t_lvl_sel         r_sel1, r_sel2;
    logic [29:0]      r_y;
    logic [27:0]      r_z;
    logic [LVL_W-1:0] r_q0, r_m1a, r_spa, r_m1b, r_spb, r_lvl;

    t_lvl_sel         w_sel;
    logic [HUE_W-1:0] w_xh;
    logic [50:0]      w_p;
    logic [56:0]      w_pz;
    logic [28:0]      w_q15, w_rem;
    logic [LVL_W-1:0] w_q, w_lvl;
    logic [TW-1:0]    w_t;
    logic [CW:0]      w_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // Hue sector: rising ramp, top, falling ramp, bottom
    always_comb begin
        w_xh  = i_hue;
        w_sel = SEL_LOW;
        if (i_hue < DEG60) begin
            w_sel = SEL_RAMP;
        end else if (i_hue < DEG180) begin
            w_sel = SEL_HIGH;
        end else if (i_hue < DEG240) begin
            w_sel = SEL_RAMP;
            w_xh  = DEG240 - i_hue;
        end
        w_p = i_span * w_xh[25:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y    <= w_p[49:20];
            r_sel1 <= w_sel;
            r_m1a  <= i_m1;
            r_spa  <= i_span;
        end
    end

    // Divide by 60: drop two bits, then a reciprocal of 15
    assign w_pz = r_y[29:2] * RECIP15;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0   <= w_pz[56:32];
            r_z    <= r_y[29:2];
            r_sel2 <= r_sel1;
            r_m1b  <= r_m1a;
            r_spb  <= r_spa;
        end
    end

    always_comb begin
        w_q15 = {r_q0, 4'b0} - {4'b0, r_q0};
        w_rem = {1'b0, r_z} - w_q15;
        w_q   = (w_rem >= 29'd15) ? (r_q0 + 1'b1) : r_q0;
        unique case (r_sel2)
            SEL_RAMP: w_lvl = r_m1b + w_q;
            SEL_HIGH: w_lvl = r_m1b + r_spb;
            default:  w_lvl = r_m1b;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lvl <= w_lvl;
        end
    end

    // level * CH_MAX / 2^24
    always_comb begin
        w_t = {r_lvl, {CW{1'b0}}} - {{CW{1'b0}}, r_lvl};
        w_o = w_t[TW-1:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_chan <= (w_o > {1'b0, CH}) ? 16'(CH) : 16'(w_o);
        end
    end

    assign o_valid = r_v[3];

endmodule
